[hdl/message_frame_deframer_unit_defines.svh]
`ifndef MESSAGE_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define MESSAGE_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle implication");

// next-cycle implication, sampled on clk, off during reset
`define MFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle implication");

`endif

[hdl/mfd_pkg.sv]
`default_nettype none

package mfd_pkg;

    localparam int SESSION_ID_BYTES_DEF = 16;
    localparam int LEN_W                = 16;
    localparam int BYTE_W               = 8;
    localparam int PHASE_W              = 4;

    localparam logic [BYTE_W-1:0] MAX_VERSION_RST = 8'd1;

    // parse phases, also used as the field tag of the byte taken in that phase
    localparam logic [PHASE_W-1:0] PH_VERSION = 4'd0;
    localparam logic [PHASE_W-1:0] PH_METHOD  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_SID     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SLEN_HI = 4'd3;
    localparam logic [PHASE_W-1:0] PH_SLEN_LO = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SPAY    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_PLEN_HI = 4'd6;
    localparam logic [PHASE_W-1:0] PH_PLEN_LO = 4'd7;
    localparam logic [PHASE_W-1:0] PH_PAY     = 4'd8;
    localparam logic [PHASE_W-1:0] PH_BAD     = 4'd9;

    localparam logic [PHASE_W-1:0] KIND_REJECT = 4'd9;

endpackage

`default_nettype wire

[hdl/message_frame_deframer_unit.sv]
`default_nettype none
// Byte-serial message deframer. Each byte transfer on the input channel
// (data_byte) gives exactly one result transfer on the output channel: the
// byte itself, its field tag, its offset within the field, a last-of-field
// mark, frame_done on the byte that closes a message, and error for a version
// above max_version and for every byte after that until reset. The block takes
// one byte per clock while the output channel takes its results; a result is
// registered after a single pass through the phase decode and the 16-bit index
// compare and appears in the cycle after its byte. in_ready is high whenever the
// result register is empty or is being emptied in the same cycle. max_version is
// written through cfg_wr_en / cfg_wr_data; the user must write it only while the
// block is idle, which the block itself does not enforce. It resets to 1.
`include "message_frame_deframer_unit_defines.svh"

module message_frame_deframer_unit #(
    parameter int SESSION_ID_BYTES = mfd_pkg::SESSION_ID_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // configuration
    input  wire logic                        cfg_wr_en,
    input  wire logic [mfd_pkg::BYTE_W-1:0]  cfg_wr_data,

    // input channel
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic [mfd_pkg::BYTE_W-1:0]  data_byte,

    // output channel
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      logic [mfd_pkg::BYTE_W-1:0]  byte_value,
    output      logic [3:0]                  field_kind,
    output      logic [mfd_pkg::LEN_W-1:0]   byte_offset,
    output      logic                        field_last,
    output      logic                        frame_done,
    output      logic                        error
);

    localparam logic [mfd_pkg::LEN_W-1:0] SID_LEN = mfd_pkg::LEN_W'(SESSION_ID_BYTES);

    // parser state
    logic [mfd_pkg::BYTE_W-1:0]  max_version_reg;
    logic [mfd_pkg::PHASE_W-1:0] phase_reg,  phase_next;
    logic [mfd_pkg::LEN_W-1:0]   index_reg,  index_next;
    logic [mfd_pkg::LEN_W-1:0]   length_reg, length_next;

    // result register
    logic                        out_valid_reg;
    logic [mfd_pkg::BYTE_W-1:0]  value_reg;
    logic [3:0]                  kind_reg,   kind_next;
    logic [mfd_pkg::LEN_W-1:0]   offset_reg, offset_next;
    logic                        last_reg,   last_next;
    logic                        done_reg,   done_next;
    logic                        err_reg,    err_next;

    logic                        in_xfer;
    logic                        more_left;
    logic [mfd_pkg::LEN_W-1:0]   low_len;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // index + 1 < length, carried one bit wider so the top index cannot wrap
    assign more_left = ({1'b0, index_reg} + 17'd1) < {1'b0, length_reg};
    assign low_len   = {length_reg[mfd_pkg::LEN_W-1:mfd_pkg::BYTE_W], data_byte};

    // phase decode: next state and the result for the byte on the input
    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        length_next = length_reg;
        kind_next   = mfd_pkg::KIND_REJECT;
        offset_next = '0;
        last_next   = 1'b0;
        done_next   = 1'b0;
        err_next    = 1'b0;
        case (phase_reg)
            mfd_pkg::PH_VERSION:
            begin
                if (data_byte <= max_version_reg)
                begin
                    kind_next  = mfd_pkg::PH_VERSION;
                    last_next  = 1'b1;
                    phase_next = mfd_pkg::PH_METHOD;
                end
                else
                begin
                    err_next   = 1'b1;
                    phase_next = mfd_pkg::PH_BAD;
                end
            end
            mfd_pkg::PH_METHOD:
            begin
                kind_next   = mfd_pkg::PH_METHOD;
                last_next   = 1'b1;
                length_next = SID_LEN;
                index_next  = '0;
                phase_next  = mfd_pkg::PH_SID;
            end
            mfd_pkg::PH_SID, mfd_pkg::PH_SPAY, mfd_pkg::PH_PAY:
            begin
                // counted fields share the index walk
                kind_next   = phase_reg;
                offset_next = index_reg;
                if (more_left)
                begin
                    index_next = index_reg + 16'd1;
                end
                else
                begin
                    last_next = 1'b1;
                    case (phase_reg)
                        mfd_pkg::PH_SID:  phase_next = mfd_pkg::PH_SLEN_HI;
                        mfd_pkg::PH_SPAY: phase_next = mfd_pkg::PH_PLEN_HI;
                        default:
                        begin
                            done_next  = 1'b1;
                            phase_next = mfd_pkg::PH_VERSION;
                        end
                    endcase
                end
            end
            mfd_pkg::PH_SLEN_HI, mfd_pkg::PH_PLEN_HI:
            begin
                kind_next   = phase_reg;
                last_next   = 1'b1;
                length_next = {data_byte, 8'h00};
                phase_next  = phase_reg + 4'd1;
            end
            mfd_pkg::PH_SLEN_LO:
            begin
                kind_next   = mfd_pkg::PH_SLEN_LO;
                last_next   = 1'b1;
                length_next = low_len;
                index_next  = '0;
                phase_next  = (low_len != '0) ? mfd_pkg::PH_SPAY : mfd_pkg::PH_PLEN_HI;
            end
            mfd_pkg::PH_PLEN_LO:
            begin
                kind_next   = mfd_pkg::PH_PLEN_LO;
                last_next   = 1'b1;
                length_next = low_len;
                index_next  = '0;
                if (low_len != '0)
                begin
                    phase_next = mfd_pkg::PH_PAY;
                end
                else
                begin
                    // empty payload: its low length byte closes the frame
                    done_next  = 1'b1;
                    phase_next = mfd_pkg::PH_VERSION;
                end
            end
            default:
            begin
                // stuck after a rejected version, or an unused code
                err_next   = 1'b1;
                phase_next = mfd_pkg::PH_BAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_version_reg <= mfd_pkg::MAX_VERSION_RST;
            phase_reg       <= mfd_pkg::PH_VERSION;
            index_reg       <= '0;
            length_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_version_reg <= cfg_wr_data;
            end
            if (in_xfer)
            begin
                phase_reg  <= phase_next;
                index_reg  <= index_next;
                length_reg <= length_next;
            end
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            value_reg  <= data_byte;
            kind_reg   <= kind_next;
            offset_reg <= offset_next;
            last_reg   <= last_next;
            done_reg   <= done_next;
            err_reg    <= err_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_value  = value_reg;
    assign field_kind  = kind_reg;
    assign byte_offset = offset_reg;
    assign field_last  = last_reg;
    assign frame_done  = done_reg;
    assign error       = err_reg;

    // error state is sticky until reset
    `MFD_ASSERT_NEXT(a_bad_sticky, phase_reg == mfd_pkg::PH_BAD, phase_reg == mfd_pkg::PH_BAD)
    // a flagged result carries the reject tag and never closes a frame
    `MFD_ASSERT_NOW(a_err_reject, out_valid_reg && err_reg,
        kind_reg == mfd_pkg::KIND_REJECT && !done_reg && !last_reg)
    // a frame always ends on the last byte of a field
    `MFD_ASSERT_NOW(a_done_last, out_valid_reg && done_reg, last_reg)
    // counted fields never run past their length
    `MFD_ASSERT_NOW(a_index_range,
        phase_reg == mfd_pkg::PH_SID || phase_reg == mfd_pkg::PH_SPAY ||
        phase_reg == mfd_pkg::PH_PAY, index_reg < length_reg)

endmodule

`default_nettype wire
